### rtl/core/rrtr_pkg.sv
// ----------------------------------------------------------------------------
// rrtr_pkg: shared types and constants of the round-robin task ring
// Sizes of the slot table, event and status codes, and the handoff structs.
// ----------------------------------------------------------------------------
package rrtr_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int ID_BITS    = 8;
    localparam int SLOT_BITS  = $clog2(TASK_SLOTS);

    localparam int OP_W      = 2;
    localparam int TID_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int NEW_ID_W  = 8;
    localparam int RSLOT_W   = 4;
    localparam int RID_W     = 8;

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [ID_BITS-1:0]   t_id;

    localparam t_slot USED_MAX = t_slot'(TASK_SLOTS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_CREATE_SLOT = 2'd0,
        OP_CREATE_ID   = 2'd1,
        OP_END         = 2'd2,
        OP_TICK        = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_LONE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RS_READY   = 2'd0,
        RS_RUNNING = 2'd1,
        RS_BLOCKED = 2'd2
    } t_run;

    typedef struct packed {
        logic fire;
        t_op  op;
        t_id  tid;
    } t_evt;

    typedef struct packed {
        t_status status;
        t_id     new_id;
        t_slot   cur_slot;
        t_id     cur_id;
    } t_res;

    typedef struct packed {
        t_run run;
        logic active;
    } t_view;

endpackage

### rtl/core/rrtr_if.sv
// ----------------------------------------------------------------------------
// rrtr_if: event and result channels of the round-robin task ring
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface rrtr_in_if;
    import rrtr_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [TID_W-1:0] task_id;

    modport source (output valid, output op, output task_id, input ready);
    modport sink   (input valid, input op, input task_id, output ready);
endinterface

interface rrtr_out_if;
    import rrtr_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NEW_ID_W-1:0] new_id;
    logic [RSLOT_W-1:0]  running_slot;
    logic [RID_W-1:0]    running_id;

    modport source (
        output valid, output status, output new_id,
        output running_slot, output running_id, input ready
    );
    modport sink (
        input valid, input status, input new_id,
        input running_slot, input running_id, output ready
    );
endinterface

### rtl/core/rrtr_table.sv
// ----------------------------------------------------------------------------
// rrtr_table: slot table and ring pointers of the round-robin task ring
// Applies one event per cycle on cycles with fire set, and gives the result of that event.
// ----------------------------------------------------------------------------
module rrtr_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rrtr_pkg::t_evt i_evt,
    output rrtr_pkg::t_res o_res,
    output rrtr_pkg::t_view o_view
);
    import rrtr_pkg::*;

    t_id   r_id     [TASK_SLOTS];
    t_run  r_run    [TASK_SLOTS];
    logic  r_active [TASK_SLOTS];
    t_slot r_next   [TASK_SLOTS];

    t_slot r_cur_slot;
    t_slot r_cur_next;
    t_id   r_cur_id;
    t_slot r_used;

    t_slot                 n_slot;
    logic                  w_full;
    logic                  w_create;
    logic                  w_tick;
    t_id                   w_cre_id;
    logic [TASK_SLOTS-1:0] w_end_hit;

    assign n_slot   = r_used + t_slot'(1);
    assign w_full   = (r_used >= USED_MAX);
    assign w_create = (i_evt.op == OP_CREATE_SLOT) || (i_evt.op == OP_CREATE_ID);
    assign w_tick   = (i_evt.op == OP_TICK) && (r_used != '0);

    always_comb begin
        unique case (i_evt.op)
            OP_CREATE_SLOT: w_cre_id = t_id'(n_slot);
            default:        w_cre_id = i_evt.tid;
        endcase
    end

    always_comb begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            w_end_hit[i] = (t_slot'(i) <= r_used) && (r_id[i] == i_evt.tid);
        end
    end

    always_comb begin
        o_res.status = ST_DONE;
        if (w_create && w_full) begin
            o_res.status = ST_FULL;
        end else if ((i_evt.op == OP_TICK) && (r_used == '0)) begin
            o_res.status = ST_LONE;
        end
        o_res.new_id   = (w_create && !w_full) ? w_cre_id : '0;
        o_res.cur_slot = w_tick ? r_cur_next : r_cur_slot;
        o_res.cur_id   = w_tick ? r_id[r_cur_next] : r_cur_id;
    end

    assign o_view.run    = r_run[r_cur_slot];
    assign o_view.active = r_active[r_cur_slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_cur_slot  <= '0;
            r_cur_next  <= '0;
            r_cur_id    <= '0;
            r_id[0]     <= '0;
            r_run[0]    <= RS_RUNNING;
            r_active[0] <= 1'b1;
            r_next[0]   <= '0;
        end else if (i_evt.fire) begin
            unique case (i_evt.op)
                OP_CREATE_SLOT, OP_CREATE_ID: begin
                    if (!w_full) begin
                        r_used           <= n_slot;
                        r_id[n_slot]     <= w_cre_id;
                        r_run[n_slot]    <= RS_READY;
                        r_active[n_slot] <= 1'b1;
                        r_next[n_slot]   <= r_cur_next;
                        r_next[r_cur_slot] <= n_slot;
                        r_cur_next       <= n_slot;
                    end
                end
                OP_END: begin
                    for (int i = 0; i < TASK_SLOTS; i++) begin
                        if (w_end_hit[i]) begin
                            r_active[i] <= 1'b0;
                            r_run[i]    <= RS_BLOCKED;
                        end
                    end
                end
                OP_TICK: begin
                    if (w_tick) begin
                        r_run[r_cur_slot] <= RS_READY;
                        r_run[r_cur_next] <= RS_RUNNING;
                        r_cur_slot        <= r_cur_next;
                        r_cur_id          <= r_id[r_cur_next];
                        r_cur_next        <= r_next[r_cur_next];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/round_robin_task_ring.sv
// ----------------------------------------------------------------------------
// round_robin_task_ring: round-robin task ring scheduler
// Takes create, end and tick events and reports the running task after each.
// ----------------------------------------------------------------------------
// One event beat is taken every clock cycle unless the result side stalls,
// and each gives one result beat: the event lands in an input register, the
// slot table applies it in a single pass, and the result register holds the
// answer. The rate is set by that single-pass table update; a stalled result
// side holds both registers, and the input side accepts again as soon as the
// result register frees up. Unused slots are never read, so reset needs no
// clearing pass and the block takes events in the first cycle after reset.
module round_robin_task_ring (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rrtr_in_if.sink         i_evt,
    rrtr_out_if.source      o_res
);
    import rrtr_pkg::*;

    logic r_in_valid;
    t_op  r_in_op;
    t_id  r_in_tid;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [NEW_ID_W-1:0] r_new_id;
    logic [RSLOT_W-1:0]  r_run_slot;
    logic [RID_W-1:0]    r_run_id;

    logic  w_adv;
    logic  w_fire;
    t_evt  w_evt;
    t_res  w_res;
    t_view w_view;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign w_fire      = r_in_valid && w_adv;
    assign i_evt.ready = !r_in_valid || w_adv;

    assign w_evt.fire = w_fire;
    assign w_evt.op   = r_in_op;
    assign w_evt.tid  = r_in_tid;

    rrtr_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_evt),
        .o_res   (w_res),
        .o_view  (w_view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in_op  <= t_op'(i_evt.op);
            r_in_tid <= t_id'(i_evt.task_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status   <= STATUS_W'(w_res.status);
            r_new_id   <= NEW_ID_W'(w_res.new_id);
            r_run_slot <= RSLOT_W'(w_res.cur_slot);
            r_run_id   <= RID_W'(w_res.cur_id);
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_status;
    assign o_res.new_id       = r_new_id;
    assign o_res.running_slot = r_run_slot;
    assign o_res.running_id   = r_run_id;

    a_cur_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_view.run != RS_READY)
        else $error("running slot marked ready");

    a_active_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_view.active |-> (w_view.run == RS_RUNNING))
        else $error("active running slot not in running state");

    a_beat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> r_in_valid)
        else $error("accepted event beat lost");

    a_fire_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed event gave no result beat");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the round-robin task ring
// Drives create, end and tick events with random gaps, keeps a shadow copy
// of the slot ring to predict each result beat, and checks every beat on the
// result channel under random back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import rrtr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_EVENTS = 600;

    typedef struct {
        t_op op;
        t_id tid;
        int  gap;
        bit  drain;
    } t_sched_event;

    logic i_clk;
    logic i_rst_n;

    rrtr_in_if  evt_if ();
    rrtr_out_if res_if ();

    round_robin_task_ring DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if.sink),
        .o_res   (res_if.source)
    );

    // shadow ring
    t_id   ring_id   [TASK_SLOTS];
    t_run  ring_run  [TASK_SLOTS];
    logic  ring_live [TASK_SLOTS];
    t_slot ring_next [TASK_SLOTS];
    t_slot run_slot;
    t_slot used_slots;

    t_sched_event event_queue [$];
    t_res         expected_reports [$];
    t_id          known_ids [$];
    int           gen_used     = 0;
    bit           quiet_source = 1'b0;

    t_sched_event cur_event;
    bit           holding_event = 1'b0;
    int           gap_left      = 0;
    logic         evt_taken     = 1'b0;

    int   stall_left  = 0;
    bit   quiet_sink  = 1'b0;
    logic res_taken   = 1'b0;

    t_res want;
    int   error_count = 0;
    int   cycle_count = 0;

    function automatic t_res apply_ring_event(t_op op, t_id tid);
        t_res  rep;
        t_slot fresh;
        rep.status = ST_DONE;
        rep.new_id = '0;
        case (op)
            OP_CREATE_SLOT, OP_CREATE_ID: begin
                if (used_slots >= USED_MAX) begin
                    rep.status = ST_FULL;
                end else begin
                    fresh               = used_slots + 1'b1;
                    used_slots          = fresh;
                    ring_id[fresh]      = (op == OP_CREATE_SLOT) ? t_id'(fresh) : tid;
                    ring_run[fresh]     = RS_READY;
                    ring_live[fresh]    = 1'b1;
                    ring_next[fresh]    = ring_next[run_slot];
                    ring_next[run_slot] = fresh;
                    rep.new_id          = ring_id[fresh];
                end
            end
            OP_END: begin
                for (int s = 0; s < TASK_SLOTS; s++) begin
                    if (s <= used_slots && ring_id[s] == tid) begin
                        ring_live[s] = 1'b0;
                        ring_run[s]  = RS_BLOCKED;
                    end
                end
            end
            OP_TICK: begin
                if (used_slots == '0) begin
                    rep.status = ST_LONE;
                end else begin
                    ring_run[run_slot] = RS_READY;
                    run_slot           = ring_next[run_slot];
                    ring_run[run_slot] = RS_RUNNING;
                end
            end
        endcase
        rep.cur_slot = run_slot;
        rep.cur_id   = ring_id[run_slot];
        return rep;
    endfunction

    task automatic add_event(input t_op op, input t_id tid, input bit drain = 1'b0);
        t_sched_event ev;
        ev.op    = op;
        ev.tid   = tid;
        ev.drain = drain;
        ev.gap   = quiet_source ? 0 : $urandom_range(0, 19);
        if ((op == OP_CREATE_SLOT || op == OP_CREATE_ID) && gen_used < TASK_SLOTS - 1) begin
            gen_used++;
            known_ids.push_back(op == OP_CREATE_SLOT ? t_id'(gen_used) : tid);
        end
        event_queue.push_back(ev);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // event driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.valid <= 1'b0;
        end else if (!evt_if.valid || evt_taken) begin
            if (!holding_event && event_queue.size() > 0) begin
                cur_event     = event_queue.pop_front();
                holding_event = 1'b1;
                gap_left      = cur_event.gap;
            end
            if (holding_event && gap_left > 0) begin
                gap_left--;
                evt_if.valid <= 1'b0;
            end else if (holding_event &&
                         !(cur_event.drain && expected_reports.size() > 0)) begin
                evt_if.valid   <= 1'b1;
                evt_if.op      <= cur_event.op;
                evt_if.task_id <= cur_event.tid;
                holding_event   = 1'b0;
            end else begin
                evt_if.valid <= 1'b0;
            end
        end
    end

    // result sink
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                if ($urandom_range(0, 39) == 0) quiet_sink = !quiet_sink;
                stall_left = quiet_sink ? 0 : $urandom_range(0, 19);
            end
            if (!res_if.ready || res_taken) begin
                if (stall_left > 0) begin
                    stall_left--;
                    res_if.ready <= 1'b0;
                end else begin
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    // predict on event beats, check result beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_taken <= 1'b0;
            res_taken <= 1'b0;
        end else begin
            evt_taken <= evt_if.valid && evt_if.ready;
            res_taken <= res_if.valid && res_if.ready;
            if (evt_if.valid && evt_if.ready)
                expected_reports.push_back(
                    apply_ring_event(t_op'(evt_if.op), evt_if.task_id));
            if (res_if.valid && res_if.ready) begin
                if (expected_reports.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result beat: status %0d new_id %0d slot %0d id %0d",
                                 res_if.status, res_if.new_id,
                                 res_if.running_slot, res_if.running_id);
                end else begin
                    want = expected_reports.pop_front();
                    if (want.status !== res_if.status || want.new_id !== res_if.new_id ||
                        want.cur_slot !== res_if.running_slot ||
                        want.cur_id !== res_if.running_id) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     want.status, want.new_id, want.cur_slot, want.cur_id,
                                     res_if.status, res_if.new_id,
                                     res_if.running_slot, res_if.running_id);
                    end
                end
            end
        end
    end

    initial begin
        int pick;
        bit drain_here;

        i_rst_n        = 1'b0;
        evt_if.valid   = 1'b0;
        evt_if.op      = OP_CREATE_SLOT;
        evt_if.task_id = '0;
        res_if.ready   = 1'b0;

        for (int s = 0; s < TASK_SLOTS; s++) begin
            ring_id[s]   = '0;
            ring_run[s]  = RS_READY;
            ring_live[s] = 1'b0;
            ring_next[s] = '0;
        end
        ring_run[0]  = RS_RUNNING;
        ring_live[0] = 1'b1;
        run_slot     = '0;
        used_slots   = '0;
        known_ids.push_back(t_id'(0));

        add_event(OP_TICK, t_id'($urandom));
        add_event(OP_END, t_id'(77));
        add_event(OP_END, t_id'(0));
        add_event(OP_TICK, t_id'($urandom));
        add_event(OP_CREATE_ID, t_id'(255));
        add_event(OP_TICK, t_id'($urandom));
        add_event(OP_END, t_id'(255));
        add_event(OP_CREATE_SLOT, t_id'($urandom));
        add_event(OP_TICK, t_id'($urandom));
        add_event(OP_TICK, t_id'($urandom));
        add_event(OP_CREATE_ID, t_id'(0));
        add_event(OP_END, t_id'(0));
        for (int g = 0; g < 4; g++) begin
            add_event(OP_CREATE_SLOT, t_id'($urandom));
            add_event(OP_CREATE_ID, g[0] ? t_id'(8'hAA) : t_id'(8'h55));
            add_event(OP_TICK, t_id'($urandom));
        end
        add_event(OP_CREATE_ID, t_id'($urandom));
        add_event(OP_CREATE_SLOT, t_id'($urandom));
        add_event(OP_CREATE_SLOT, t_id'($urandom));
        add_event(OP_CREATE_ID, t_id'($urandom));

        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n % 60 == 0) quiet_source = ($urandom_range(0, 3) == 0);
            drain_here = (n == 0 || n == 300);
            pick       = $urandom_range(0, 99);
            if (pick < 12)
                add_event(pick[0] ? OP_CREATE_ID : OP_CREATE_SLOT, t_id'($urandom),
                          drain_here);
            else if (pick < 45)
                add_event(OP_END, ($urandom_range(0, 3) == 0) ? t_id'($urandom) :
                          known_ids[$urandom_range(0, known_ids.size() - 1)], drain_here);
            else
                add_event(OP_TICK, t_id'($urandom), drain_here);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (event_queue.size() > 0 || holding_event || evt_if.valid ||
               expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
